// ----- rtl/dirty_region_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// dirty_region_tracker_macros
// Assertion macros shared by the dirty region tracker rtl.
// ----------------------------------------------------------------------------
`ifndef DIRTY_REGION_TRACKER_MACROS_SVH
`define DIRTY_REGION_TRACKER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dirty region tracker: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dirty region tracker: next-cycle check failed");

`endif

// ----- rtl/drt_pkg.sv -----
// ----------------------------------------------------------------------------
// drt_pkg
// Types and constants of the dirty region tracker.
// ----------------------------------------------------------------------------
package drt_pkg;

  // field widths
  localparam int RECT_W     = 12;
  localparam int EXT_W      = 14;
  localparam int COORD_W    = 9;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CMD_W      = 2;

  // command codes, code 3 is unused and ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_MARK    = 2'd0,
    CMD_PRESENT = 2'd1,
    CMD_FULL    = 2'd2
  } cmd_t;

  // clipped rectangle, right and bottom exclusive
  typedef struct packed {
    logic               keep;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
  } clip_t;

endpackage

// ----- rtl/drt_clip.sv -----
// ----------------------------------------------------------------------------
// drt_clip
// Clips a signed rectangle to the panel and flags whether anything is left.
// ----------------------------------------------------------------------------
module drt_clip
  import drt_pkg::*;
#(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 320
) (
  input  logic signed [RECT_W-1:0] rect_x,
  input  logic signed [RECT_W-1:0] rect_y,
  input  logic signed [RECT_W-1:0] rect_w,
  input  logic signed [RECT_W-1:0] rect_h,
  output clip_t                    clip
);

  localparam logic signed [EXT_W-1:0] W_LIM = EXT_W'(PANEL_WIDTH);
  localparam logic signed [EXT_W-1:0] H_LIM = EXT_W'(PANEL_HEIGHT);
  localparam int PAD = EXT_W - RECT_W;

  logic signed [EXT_W-1:0] x_e, y_e, w_e, h_e;
  logic signed [EXT_W-1:0] x_end, y_end;
  logic signed [EXT_W-1:0] left_e, top_e, right_e, bottom_e;

  // sign extension and far edges
  assign x_e   = $signed({{PAD{rect_x[RECT_W-1]}}, rect_x});
  assign y_e   = $signed({{PAD{rect_y[RECT_W-1]}}, rect_y});
  assign w_e   = $signed({{PAD{rect_w[RECT_W-1]}}, rect_w});
  assign h_e   = $signed({{PAD{rect_h[RECT_W-1]}}, rect_h});
  assign x_end = x_e + w_e;
  assign y_end = y_e + h_e;

  // clamp to the panel
  assign left_e   = (x_e < 0) ? '0 : x_e;
  assign top_e    = (y_e < 0) ? '0 : y_e;
  assign right_e  = (x_end > W_LIM) ? W_LIM : x_end;
  assign bottom_e = (y_end > H_LIM) ? H_LIM : y_end;

  // kept edges always lie within 0..511
  always_comb begin
    clip.keep   = (w_e > 0) && (h_e > 0) && (left_e < right_e) && (top_e < bottom_e);
    clip.left   = left_e[COORD_W-1:0];
    clip.top    = top_e[COORD_W-1:0];
    clip.right  = right_e[COORD_W-1:0];
    clip.bottom = bottom_e[COORD_W-1:0];
  end

endmodule

// ----- rtl/dirty_region_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty_region_tracker
// Keeps the bounding box of changed pixels and reports it on present.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the s_ stream, cmd in s_tuser and the rectangle
// in s_tdata. A mark request grows the stored dirty box and gives no result.
// A present request gives one result on the m_ stream with the inclusive
// window and clears the box; present-full always gives the whole panel.
// Code 3 is ignored.
// Timing: a taken request sits in the input register, and its result is
// registered in the result register when it advances, raising m_tvalid.
// Throughput: one request per cycle when not stalled; clip, compare and union
// are one pass of logic between the input register and the box and result registers.
// Stall: a waiting result holds in the result register while further marks
// still flow; s_tready drops only when a present request waits behind an
// untaken result.
// Reset: rst clears the dirty box to zero and both valid flags of the pipe.
// ----------------------------------------------------------------------------
`include "dirty_region_tracker_macros.svh"

module dirty_region_tracker
  import drt_pkg::*;
#(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 320
) (
  input  logic                  clk,
  input  logic                  rst,
  // rect_x[11:0], rect_y[23:12], rect_w[35:24], rect_h[47:36]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      s_tuser,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // col_first[8:0], col_last[17:9], row_first[26:18], row_last[35:27], zero[39:36]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // window_sent[0]
  output logic                  m_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready
);

  localparam logic [COORD_W-1:0] COL_MAX = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(PANEL_HEIGHT - 1);

  // input register
  logic                     in_vld;
  logic [CMD_W-1:0]         in_cmd;
  logic signed [RECT_W-1:0] in_x, in_y, in_w, in_h;

  // dirty box
  logic               box_valid, box_valid_next;
  logic [COORD_W-1:0] box_left, box_left_next;
  logic [COORD_W-1:0] box_top, box_top_next;
  logic [COORD_W-1:0] box_right_excl, box_right_excl_next;
  logic [COORD_W-1:0] box_bottom_excl, box_bottom_excl_next;

  // result register
  logic               out_vld;
  logic               out_sent, out_sent_next;
  logic [COORD_W-1:0] col_first, col_first_next;
  logic [COORD_W-1:0] col_last, col_last_next;
  logic [COORD_W-1:0] row_first, row_first_next;
  logic [COORD_W-1:0] row_last, row_last_next;

  logic  produce;
  logic  adv;
  clip_t clip;

  drt_clip #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_clip (
    .rect_x (in_x),
    .rect_y (in_y),
    .rect_w (in_w),
    .rect_h (in_h),
    .clip   (clip)
  );

  // flow control
  assign produce  = in_vld && ((in_cmd == CMD_PRESENT) || (in_cmd == CMD_FULL));
  assign adv      = in_vld && (!produce || !out_vld || m_tready);
  assign s_tready = !in_vld || adv;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_cmd <= s_tuser;
      in_x   <= s_tdata[11:0];
      in_y   <= s_tdata[23:12];
      in_w   <= s_tdata[35:24];
      in_h   <= s_tdata[47:36];
    end
  end

  // box update and result selection
  always_comb begin
    box_valid_next       = box_valid;
    box_left_next        = box_left;
    box_top_next         = box_top;
    box_right_excl_next  = box_right_excl;
    box_bottom_excl_next = box_bottom_excl;
    out_sent_next        = 1'b0;
    col_first_next       = '0;
    col_last_next        = '0;
    row_first_next       = '0;
    row_last_next        = '0;
    case (in_cmd)
      CMD_MARK: begin
        if (clip.keep) begin
          box_valid_next = 1'b1;
          if (!box_valid) begin
            box_left_next        = clip.left;
            box_top_next         = clip.top;
            box_right_excl_next  = clip.right;
            box_bottom_excl_next = clip.bottom;
          end else begin
            if (clip.left < box_left)          box_left_next        = clip.left;
            if (clip.top < box_top)            box_top_next         = clip.top;
            if (clip.right > box_right_excl)   box_right_excl_next  = clip.right;
            if (clip.bottom > box_bottom_excl) box_bottom_excl_next = clip.bottom;
          end
        end
      end
      CMD_PRESENT: begin
        box_valid_next = 1'b0;
        if (box_valid && (box_left < box_right_excl) && (box_top < box_bottom_excl)) begin
          out_sent_next  = 1'b1;
          col_first_next = box_left;
          col_last_next  = box_right_excl - 1'b1;
          row_first_next = box_top;
          row_last_next  = box_bottom_excl - 1'b1;
        end
      end
      CMD_FULL: begin
        box_valid_next = 1'b0;
        out_sent_next  = 1'b1;
        col_last_next  = COL_MAX;
        row_last_next  = ROW_MAX;
      end
      default: begin
      end
    endcase
  end

  // box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid       <= 1'b0;
      box_left        <= '0;
      box_top         <= '0;
      box_right_excl  <= '0;
      box_bottom_excl <= '0;
    end else if (adv) begin
      box_valid       <= box_valid_next;
      box_left        <= box_left_next;
      box_top         <= box_top_next;
      box_right_excl  <= box_right_excl_next;
      box_bottom_excl <= box_bottom_excl_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && produce) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
    if (adv && produce) begin
      out_sent  <= out_sent_next;
      col_first <= col_first_next;
      col_last  <= col_last_next;
      row_first <= row_first_next;
      row_last  <= row_last_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_sent;
  assign m_tdata  = {{(OUT_DATA_W - 4 * COORD_W){1'b0}}, row_last, row_first, col_last, col_first};

  // checks
  `DRT_ASSERT_SAME(a_window_order, clk, rst, m_tvalid && m_tuser,
    (col_first <= col_last) && (row_first <= row_last) &&
    (col_last <= COL_MAX) && (row_last <= ROW_MAX))
  `DRT_ASSERT_SAME(a_empty_zero, clk, rst, m_tvalid && !m_tuser,
    (col_first == '0) && (col_last == '0) && (row_first == '0) && (row_last == '0))
  `DRT_ASSERT_NEXT(a_present_clears, clk, rst, adv && produce, !box_valid && m_tvalid)
  `DRT_ASSERT_NEXT(a_mark_sets, clk, rst, adv && (in_cmd == CMD_MARK) && clip.keep, box_valid)
  `DRT_ASSERT_SAME(a_stall_cause, clk, rst, !s_tready, in_vld && produce && out_vld && !m_tready)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the dirty region tracker against an in-bench model of the dirty box.
// Mark, present and present-full requests go in on the s_ stream, with
// random idle bursts on the input and random stalls on the output. Each
// accepted request updates the model, and each window taken from the m_
// stream is compared field by field with the oldest predicted window.
// ----------------------------------------------------------------------------
module testbench;
  import drt_pkg::*;

  localparam int PANEL_W = 320;
  localparam int PANEL_H = 320;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  // code 3 is unused, the block should ignore it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // one window as the block should report it
  typedef struct packed {
    logic               sent;
    logic [COORD_W-1:0] col_first;
    logic [COORD_W-1:0] col_last;
    logic [COORD_W-1:0] row_first;
    logic [COORD_W-1:0] row_last;
  } window_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [CMD_W-1:0]      s_tuser;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;

  // model of the dirty box, right and bottom exclusive
  logic               dirty_valid;
  logic [COORD_W-1:0] dirty_left;
  logic [COORD_W-1:0] dirty_top;
  logic [COORD_W-1:0] dirty_right;
  logic [COORD_W-1:0] dirty_bottom;

  window_t pending_windows[$];
  window_t want;

  int errors = 0;
  int cycles = 0;
  int marks_sent = 0;
  int presents_sent = 0;
  int ignored_sent = 0;
  int windows_checked = 0;
  int empty_windows = 0;

  // idle and stall controls
  logic idle_on = 1'b1;
  logic stall_on = 1'b1;
  int   stall_left = 0;

  dirty_region_tracker #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d windows outstanding", $time, pending_windows.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // output stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // update the dirty box model for one accepted request
  function automatic void apply_command(input logic [CMD_W-1:0] code,
                                        input logic [IN_DATA_W-1:0] rect);
    int      x, y, w, h;
    int      l, t, r, b;
    window_t win;
    x = int'($signed(rect[11:0]));
    y = int'($signed(rect[23:12]));
    w = int'($signed(rect[35:24]));
    h = int'($signed(rect[47:36]));
    win = '0;
    case (code)
      CMD_MARK: begin
        marks_sent++;
        if (w > 0 && h > 0) begin
          l = (x < 0) ? 0 : x;
          t = (y < 0) ? 0 : y;
          r = (x + w > PANEL_W) ? PANEL_W : x + w;
          b = (y + h > PANEL_H) ? PANEL_H : y + h;
          // empty clip leaves the box alone
          if (l < r && t < b) begin
            if (!dirty_valid) begin
              dirty_left = COORD_W'(l);
              dirty_top = COORD_W'(t);
              dirty_right = COORD_W'(r);
              dirty_bottom = COORD_W'(b);
              dirty_valid = 1'b1;
            end else begin
              if (l < dirty_left) dirty_left = COORD_W'(l);
              if (t < dirty_top) dirty_top = COORD_W'(t);
              if (r > dirty_right) dirty_right = COORD_W'(r);
              if (b > dirty_bottom) dirty_bottom = COORD_W'(b);
            end
          end
        end
      end
      CMD_PRESENT: begin
        presents_sent++;
        if (dirty_valid && dirty_left < dirty_right && dirty_top < dirty_bottom) begin
          win.sent = 1'b1;
          win.col_first = dirty_left;
          win.col_last = dirty_right - 1'b1;
          win.row_first = dirty_top;
          win.row_last = dirty_bottom - 1'b1;
        end
        dirty_valid = 1'b0;
        pending_windows.push_back(win);
      end
      CMD_FULL: begin
        presents_sent++;
        win.sent = 1'b1;
        win.col_last = COORD_W'(PANEL_W - 1);
        win.row_last = COORD_W'(PANEL_H - 1);
        dirty_valid = 1'b0;
        pending_windows.push_back(win);
      end
      default: ignored_sent++;
    endcase
  endfunction

  task automatic report_mismatch(input string fname, input int want_v, input int got_v);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want_v, got_v);
    errors++;
  endtask

  // results are sampled at the falling edge, taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected window, expected none actual sent=%0d data=%h",
                 $time, m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_windows.pop_front();
        windows_checked++;
        if (!want.sent) empty_windows++;
        if (m_tuser !== want.sent) report_mismatch("window_sent", want.sent, m_tuser);
        if (m_tdata[8:0] !== want.col_first)
          report_mismatch("col_first", want.col_first, m_tdata[8:0]);
        if (m_tdata[17:9] !== want.col_last)
          report_mismatch("col_last", want.col_last, m_tdata[17:9]);
        if (m_tdata[26:18] !== want.row_first)
          report_mismatch("row_first", want.row_first, m_tdata[26:18]);
        if (m_tdata[35:27] !== want.row_last)
          report_mismatch("row_last", want.row_last, m_tdata[35:27]);
        if (m_tdata[39:36] !== 4'd0) report_mismatch("pad bits", 0, m_tdata[39:36]);
      end
    end
  end

  // send one request, called and returning at a rising edge
  task automatic send_request(input logic [CMD_W-1:0] code,
                              input logic [IN_DATA_W-1:0] rect);
    int   gap;
    logic taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= code;
    s_tdata <= rect;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    apply_command(code, rect);
  endtask

  task automatic mark_rect(input int x, input int y, input int w, input int h);
    send_request(CMD_MARK, {h[11:0], w[11:0], y[11:0], x[11:0]});
  endtask

  // rectangle mix: mostly near the panel, some at the field extremes, some raw
  function automatic logic [IN_DATA_W-1:0] random_rect();
    int x, y, w, h;
    int picks[6];
    logic [63:0] raw;
    picks = '{-2048, -1, 0, 319, 320, 2047};
    case ($urandom_range(0, 9))
      0, 1: begin
        raw = {$urandom(), $urandom()};
        return raw[IN_DATA_W-1:0];
      end
      2: begin
        x = picks[$urandom_range(0, 5)];
        y = picks[$urandom_range(0, 5)];
        w = picks[$urandom_range(0, 5)];
        h = picks[$urandom_range(0, 5)];
      end
      default: begin
        x = $urandom_range(0, 420) - 50;
        y = $urandom_range(0, 420) - 50;
        w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8) - 4 : $urandom_range(1, 160);
        h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8) - 4 : $urandom_range(1, 160);
      end
    endcase
    return {h[11:0], w[11:0], y[11:0], x[11:0]};
  endfunction

  // one random request, marks dominate so the box usually has content
  task automatic send_random_request();
    logic [63:0] raw;
    int pick;
    raw = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    if (pick < 70) send_request(CMD_MARK, random_rect());
    else if (pick < 88) send_request(CMD_PRESENT, raw[IN_DATA_W-1:0]);
    else if (pick < 94) send_request(CMD_FULL, raw[IN_DATA_W-1:0]);
    else send_request(CMD_UNUSED, random_rect());
  endtask

  // field extremes, dropped and clipped marks, union, clearing, unused code
  task automatic test_directed();
    send_request(CMD_PRESENT, '0);
    send_request(CMD_FULL, '1);
    mark_rect(10, 20, 5, 6);
    mark_rect(30, 40, 0, 8);
    mark_rect(30, 40, 8, -2048);
    mark_rect(-2048, 5, 2047, 5);
    mark_rect(320, 5, 5, 5);
    mark_rect(2047, 2047, 2047, 2047);
    send_request(CMD_UNUSED, {12'd320, 12'd320, 12'd0, 12'd0});
    send_request(CMD_PRESENT, '0);
    send_request(CMD_PRESENT, '1);
    mark_rect(-5, -7, 300, 400);
    mark_rect(319, 0, 1, 1);
    send_request(CMD_PRESENT, '0);
    mark_rect(100, 100, 1, 1);
    send_request(CMD_PRESENT, '0);
    mark_rect(0, 0, 320, 320);
    send_request(CMD_FULL, '0);
    send_request(CMD_PRESENT, '0);
    mark_rect(-100, -100, 2047, 2047);
    mark_rect(50, 60, 2, 2);
    send_request(CMD_PRESENT, '0);
  endtask

  // random traffic with idle bursts and output stalls
  task automatic test_random_traffic(input int count);
    repeat (count) send_random_request();
  endtask

  // random traffic at full rate, no idling on either side
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    stall_on = 1'b0;
    repeat (count) send_random_request();
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser <= CMD_MARK;
    s_tdata <= '0;
    dirty_valid = 1'b0;
    dirty_left = '0;
    dirty_top = '0;
    dirty_right = '0;
    dirty_bottom = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(725);
    test_back_to_back(125);
    s_tvalid <= 1'b0;

    // drain outstanding windows, then watch for strays
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d marks, %0d presents and %0d ignored codes",
             marks_sent, presents_sent, ignored_sent);
    $display("%0d windows checked, %0d of them empty", windows_checked, empty_windows);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
